// ===== src/tlut_pkg.sv =====
// ----------------------------------------------------------------------------
// tlut_pkg: shared definitions for the trilinear 3D color LUT
// Port widths, parameter defaults, item kinds and stage enable bundle.
// ----------------------------------------------------------------------------
package tlut_pkg;

  // defaults for the top-level parameters
  localparam int MAX_CUBE_SIZE_DEF   = 33;
  localparam int COLOR_FRAC_BITS_DEF = 12;
  localparam int ENTRY_WIDTH_DEF     = 16;

  // fixed port widths
  localparam int ADDR_W = 17;
  localparam int CFG_W  = 6;

  // cube_size after reset (clamped to the configured maximum at the top)
  localparam int CUBE_SIZE_RESET = 33;

  localparam int NUM_CH = 3;

  // request kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // load enables of the blend pipeline stages
  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } blend_en_t;

endpackage

// ===== src/tlut_ram.sv =====
// ----------------------------------------------------------------------------
// tlut_ram: generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module tlut_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== src/tlut_store.sv =====
// ----------------------------------------------------------------------------
// tlut_store: cube storage
// Six copies of the flat cube, each split into even and odd address banks
// with two read ports, give twelve corner pairs (24 entries) per cycle while rd_en_i is high.
// ----------------------------------------------------------------------------
module tlut_store #(
  parameter int EW    = 16,
  parameter int AW    = 17,
  parameter int DEPTH = 107811
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        pair_addr_i [12],
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [EW-1:0]        wr_data_i,
  output logic signed [EW-1:0] corner_o [3][8]
);
  import tlut_pkg::*;

  localparam int BD = (DEPTH + 1) / 2;
  localparam int BW = $clog2(BD);

  logic [EW-1:0] rd_even [12];
  logic [EW-1:0] rd_odd  [12];
  logic          par_q   [12];
  logic [AW-1:0] addr_p1 [12];

  for (genvar j = 0; j < 12; j++) begin : g_addr
    assign addr_p1[j] = pair_addr_i[j] + AW'(1);
  end

  for (genvar c = 0; c < 6; c++) begin : g_copy
    tlut_ram #(.WIDTH(EW), .DEPTH(BD)) u_even (
      .clk_i     (clk_i),
      .we_i      (wr_en_i && !wr_addr_i[0]),
      .waddr_i   (wr_addr_i[BW:1]),
      .wdata_i   (wr_data_i),
      .re_i      (rd_en_i),
      .raddr_a_i (addr_p1[2*c][BW:1]),
      .raddr_b_i (addr_p1[2*c+1][BW:1]),
      .rdata_a_o (rd_even[2*c]),
      .rdata_b_o (rd_even[2*c+1])
    );
    tlut_ram #(.WIDTH(EW), .DEPTH(BD)) u_odd (
      .clk_i     (clk_i),
      .we_i      (wr_en_i && wr_addr_i[0]),
      .waddr_i   (wr_addr_i[BW:1]),
      .wdata_i   (wr_data_i),
      .re_i      (rd_en_i),
      .raddr_a_i (pair_addr_i[2*c][BW:1]),
      .raddr_b_i (pair_addr_i[2*c+1][BW:1]),
      .rdata_a_o (rd_odd[2*c]),
      .rdata_b_o (rd_odd[2*c+1])
    );
  end

  // pair base parity picks which bank holds the lower corner
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      for (int j = 0; j < 12; j++) begin
        par_q[j] <= pair_addr_i[j][0];
      end
    end
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    for (genvar q = 0; q < 4; q++) begin : g_pair
      assign corner_o[ch][2*q]   = par_q[ch*4+q] ? rd_odd[ch*4+q]  : rd_even[ch*4+q];
      assign corner_o[ch][2*q+1] = par_q[ch*4+q] ? rd_even[ch*4+q] : rd_odd[ch*4+q];
    end
  end

endmodule

// ===== src/tlut_lerp.sv =====
// ----------------------------------------------------------------------------
// tlut_lerp: registered linear blend
// y = floor((a*(1-f) + b*f + 1/2)), computed as a + (b-a)*f, round half up.
// ----------------------------------------------------------------------------
module tlut_lerp #(
  parameter int EW = 16,
  parameter int FB = 12
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [EW-1:0] a_i,
  input  logic signed [EW-1:0] b_i,
  input  logic [FB:0]          f_i,
  output logic signed [EW-1:0] y_o
);

  localparam int DW   = EW + 1;
  localparam int PW   = EW + FB + 4;
  localparam int HALF = 1 << (FB - 1);

  logic signed [DW-1:0] diff;
  logic signed [FB+1:0] f_s;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] sum;
  logic signed [PW-1:0] shr;
  logic signed [EW-1:0] y_q;

  assign diff = DW'(b_i) - DW'(a_i);
  assign f_s  = signed'({1'b0, f_i});
  assign prod = PW'(diff) * PW'(f_s);
  assign sum  = prod + (PW'(a_i) <<< FB) + PW'(HALF);
  assign shr  = sum >>> FB;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= shr[EW-1:0];
    end
  end

  assign y_o = y_q;

endmodule

// ===== src/tlut_blend.sv =====
// ----------------------------------------------------------------------------
// tlut_blend: trilinear blend pipeline
// Red lerps, then green, then blue, each a register stage; final clamp.
// ----------------------------------------------------------------------------
module tlut_blend #(
  parameter int EW = 16,
  parameter int FB = 12
) (
  input  logic                 clk_i,
  input  tlut_pkg::blend_en_t  en_i,
  input  logic signed [EW-1:0] corner_i [3][8],
  input  logic [FB:0]          rf_i,
  input  logic [FB:0]          gf_i,
  input  logic [FB:0]          bf_i,
  input  logic                 fe_i,
  output logic [FB:0]          red_o,
  output logic [FB:0]          green_o,
  output logic [FB:0]          blue_o,
  output logic                 frame_o
);
  import tlut_pkg::*;

  localparam int XW = ((EW > FB + 2) ? EW : FB + 2) + 1;
  localparam logic signed [XW-1:0] ONE_X = XW'(1) <<< FB;

  logic [FB:0] rf4_q, gf4_q, bf4_q, gf5_q, bf5_q, bf6_q;
  logic        fe4_q, fe5_q, fe6_q, fe7_q;

  logic signed [EW-1:0] c_r [3][4];
  logic signed [EW-1:0] c_g [3][2];
  logic signed [EW-1:0] c_b [3];
  logic [FB:0]          res [3];

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      rf4_q <= rf_i;
      gf4_q <= gf_i;
      bf4_q <= bf_i;
      fe4_q <= fe_i;
    end
    if (en_i.s5) begin
      gf5_q <= gf4_q;
      bf5_q <= bf4_q;
      fe5_q <= fe4_q;
    end
    if (en_i.s6) begin
      bf6_q <= bf5_q;
      fe6_q <= fe5_q;
    end
    if (en_i.s7) begin
      fe7_q <= fe6_q;
    end
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    for (genvar q = 0; q < 4; q++) begin : g_r
      tlut_lerp #(.EW(EW), .FB(FB)) u_r (
        .clk_i (clk_i), .en_i (en_i.s5),
        .a_i (corner_i[ch][2*q]), .b_i (corner_i[ch][2*q+1]),
        .f_i (rf4_q), .y_o (c_r[ch][q])
      );
    end
    for (genvar m = 0; m < 2; m++) begin : g_g
      tlut_lerp #(.EW(EW), .FB(FB)) u_g (
        .clk_i (clk_i), .en_i (en_i.s6),
        .a_i (c_r[ch][2*m]), .b_i (c_r[ch][2*m+1]),
        .f_i (gf5_q), .y_o (c_g[ch][m])
      );
    end
    tlut_lerp #(.EW(EW), .FB(FB)) u_b (
      .clk_i (clk_i), .en_i (en_i.s7),
      .a_i (c_g[ch][0]), .b_i (c_g[ch][1]),
      .f_i (bf6_q), .y_o (c_b[ch])
    );

    // clamp to 0..1
    always_comb begin
      logic signed [XW-1:0] v;
      v = XW'(c_b[ch]);
      if (v < 0) begin
        res[ch] = '0;
      end else if (v > ONE_X) begin
        res[ch] = (FB+1)'(ONE_X);
      end else begin
        res[ch] = (FB+1)'(v);
      end
    end
  end

  assign red_o   = res[0];
  assign green_o = res[1];
  assign blue_o  = res[2];
  assign frame_o = fe7_q;

endmodule

// ===== src/trilinear_3d_color_lut_core.sv =====
// ----------------------------------------------------------------------------
// trilinear_3d_color_lut_core: 3D color LUT with trilinear interpolation
// Loads cube entries and maps RGB pixels through the cube.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_stall_o is low, loads and pixels
// freely mixed, and presents a result for each accepted pixel; loads give
// no result. The pipeline is: input register, grid position, local
// address, flat corner addresses, cube read, red blend, green blend, blue
// blend into the output register, then a combinational clamp. Sustained
// rate is one pixel per cycle while out_stall_i is low, set by the cube
// store, which keeps six copies of the cube, each split into even and odd
// banks with two read ports, so all 24 corners come out in one read. A load
// writes every copy in the same slot where pixels read, so a pixel always
// sees loads accepted ahead of it. Cube entries are undefined after reset;
// there is no clearing pass. cube_size is clamped to 2..MAX_CUBE_SIZE when
// written and its square and cube are registered after it, in time for a
// request accepted at or after the write. Addresses are flat: channel*size^3 +
// b*size^2 + g*size + r; loads at or beyond 3*MAX_CUBE_SIZE^3 are dropped.
// ----------------------------------------------------------------------------
module trilinear_3d_color_lut_core #(
  parameter int MAX_CUBE_SIZE   = tlut_pkg::MAX_CUBE_SIZE_DEF,
  parameter int COLOR_FRAC_BITS = tlut_pkg::COLOR_FRAC_BITS_DEF,
  parameter int ENTRY_WIDTH     = tlut_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [tlut_pkg::CFG_W-1:0]    cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [tlut_pkg::ADDR_W-1:0]   entry_address_i,
  input  logic signed [ENTRY_WIDTH-1:0] entry_value_i,
  input  logic [COLOR_FRAC_BITS:0]      red_in_i,
  input  logic [COLOR_FRAC_BITS:0]      green_in_i,
  input  logic [COLOR_FRAC_BITS:0]      blue_in_i,
  input  logic                          frame_end_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [COLOR_FRAC_BITS:0]      red_out_o,
  output logic [COLOR_FRAC_BITS:0]      green_out_o,
  output logic [COLOR_FRAC_BITS:0]      blue_out_o,
  output logic                          frame_last_o
);
  import tlut_pkg::*;

  localparam int FB    = COLOR_FRAC_BITS;
  localparam int EW    = ENTRY_WIDTH;
  localparam int CW    = FB + 1;
  localparam int SW    = $clog2(MAX_CUBE_SIZE + 1);
  localparam int IW    = $clog2(MAX_CUBE_SIZE);
  localparam int PSW   = CW + SW;
  localparam int S2W   = $clog2(MAX_CUBE_SIZE * MAX_CUBE_SIZE + 1);
  localparam int S3W   = $clog2(MAX_CUBE_SIZE * MAX_CUBE_SIZE * MAX_CUBE_SIZE + 1);
  localparam int DEPTH = 3 * MAX_CUBE_SIZE * MAX_CUBE_SIZE * MAX_CUBE_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int LAW   = (AW > ADDR_W) ? AW : ADDR_W;
  localparam int XW    = (SW > CFG_W) ? SW : CFG_W;
  localparam int SIZE_RST = (CUBE_SIZE_RESET > MAX_CUBE_SIZE) ? MAX_CUBE_SIZE
                                                              : CUBE_SIZE_RESET;
  localparam logic [CW-1:0] ONE_C = {1'b1, {FB{1'b0}}};

  // grid index (clamped to size-2) and fraction (0..1) of one component
  function automatic logic [IW+CW-1:0] grid_pos(input logic [CW-1:0] x,
                                                input logic [SW-1:0] sm1,
                                                input logic [SW-1:0] smx);
    logic [CW-1:0]  c;
    logic [PSW-1:0] pos;
    logic [SW-1:0]  i;
    logic [PSW-1:0] fr;
    c   = (x > ONE_C) ? ONE_C : x;
    pos = PSW'(c) * PSW'(sm1);
    i   = SW'(pos >> FB);
    if (i > smx) begin
      i = smx;
    end
    fr  = pos - (PSW'(i) << FB);
    return {IW'(i), CW'(fr)};
  endfunction

  // ---------------- size register and derived products ----------------
  logic [SW-1:0]  size_q, size_d;
  logic [S2W-1:0] s2_q;
  logic [S3W-1:0] s3_q;
  logic [XW-1:0]  cfg_ext;

  assign cfg_ext = XW'(cfg_wdata_i);

  always_comb begin
    size_d = size_q;
    if (cfg_we_i) begin
      priority if (cfg_ext < XW'(2)) begin
        size_d = SW'(2);
      end else if (cfg_ext > XW'(MAX_CUBE_SIZE)) begin
        size_d = SW'(MAX_CUBE_SIZE);
      end else begin
        size_d = SW'(cfg_ext);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SW'(SIZE_RST);
      s2_q   <= S2W'(SIZE_RST * SIZE_RST);
      s3_q   <= S3W'(SIZE_RST * SIZE_RST * SIZE_RST);
    end else begin
      size_q <= size_d;
      s2_q   <= S2W'(S2W'(size_q) * S2W'(size_q));
      s3_q   <= S3W'(S3W'(s2_q) * S3W'(size_q));
    end
  end

  // ---------------- pipeline control ----------------
  // Stage k register loads when it is empty or its content moves on.
  logic [7:0] v_q, v_d, en;
  logic       kind3_q;

  always_comb begin
    en[7] = !v_q[7] || !out_stall_i;
    for (int k = 6; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < 8; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
    // loads retire in the read slot
    v_d[4] = en[4] ? (v_q[3] && (kind3_q == KIND_PIXEL)) : v_q[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[7];

  // ---------------- stage 0: input register ----------------
  logic              kind0_q, fe0_q;
  logic [ADDR_W-1:0] addr0_q;
  logic [EW-1:0]     val0_q;
  logic [CW-1:0]     r0_q, g0_q, b0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      kind0_q <= kind_i;
      addr0_q <= entry_address_i;
      val0_q  <= entry_value_i;
      r0_q    <= red_in_i;
      g0_q    <= green_in_i;
      b0_q    <= blue_in_i;
      fe0_q   <= frame_end_i;
    end
  end

  // ---------------- stage 1: grid position ----------------
  logic [SW-1:0]     sm1, smx;
  logic [IW-1:0]     ri_d, gi_d, bi_d;
  logic [CW-1:0]     rf_d, gf_d, bf_d;
  logic              kind1_q, fe1_q;
  logic [ADDR_W-1:0] addr1_q;
  logic [EW-1:0]     val1_q;
  logic [IW-1:0]     ri1_q, gi1_q, bi1_q;
  logic [CW-1:0]     rf1_q, gf1_q, bf1_q;

  assign sm1 = size_q - SW'(1);
  assign smx = size_q - SW'(2);
  assign {ri_d, rf_d} = grid_pos(r0_q, sm1, smx);
  assign {gi_d, gf_d} = grid_pos(g0_q, sm1, smx);
  assign {bi_d, bf_d} = grid_pos(b0_q, sm1, smx);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      kind1_q <= kind0_q;
      fe1_q   <= fe0_q;
      addr1_q <= addr0_q;
      val1_q  <= val0_q;
      ri1_q   <= ri_d;
      gi1_q   <= gi_d;
      bi1_q   <= bi_d;
      rf1_q   <= rf_d;
      gf1_q   <= gf_d;
      bf1_q   <= bf_d;
    end
  end

  // ---------------- stage 2: address within a channel ----------------
  logic [S3W-1:0]    loc_d, loc2_q;
  logic              kind2_q, fe2_q;
  logic [ADDR_W-1:0] addr2_q;
  logic [EW-1:0]     val2_q;
  logic [CW-1:0]     rf2_q, gf2_q, bf2_q;

  assign loc_d = S3W'(S3W'(bi1_q) * S3W'(s2_q)) + S3W'(S3W'(gi1_q) * S3W'(size_q))
               + S3W'(ri1_q);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      kind2_q <= kind1_q;
      fe2_q   <= fe1_q;
      addr2_q <= addr1_q;
      val2_q  <= val1_q;
      loc2_q  <= loc_d;
      rf2_q   <= rf1_q;
      gf2_q   <= gf1_q;
      bf2_q   <= bf1_q;
    end
  end

  // ---------------- stage 3: flat corner-pair addresses ----------------
  // pair j = ch*4 + q, q = dg + 2*db; each pair covers r0 and r0+1
  logic [AW-1:0]     pa_d [12];
  logic [AW-1:0]     pa_q [12];
  logic              fe3_q;
  logic [ADDR_W-1:0] addr3_q;
  logic [EW-1:0]     val3_q;
  logic [CW-1:0]     rf3_q, gf3_q, bf3_q;

  always_comb begin
    logic [AW-1:0] base;
    logic [AW-1:0] a00;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      unique case (ch)
        0:       base = '0;
        1:       base = AW'(s3_q);
        default: base = AW'(s3_q) << 1;
      endcase
      a00 = base + AW'(loc2_q);
      pa_d[ch*4]   = a00;
      pa_d[ch*4+1] = a00 + AW'(size_q);
      pa_d[ch*4+2] = a00 + AW'(s2_q);
      pa_d[ch*4+3] = a00 + AW'(s2_q) + AW'(size_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      kind3_q <= kind2_q;
      fe3_q   <= fe2_q;
      addr3_q <= addr2_q;
      val3_q  <= val2_q;
      rf3_q   <= rf2_q;
      gf3_q   <= gf2_q;
      bf3_q   <= bf2_q;
      for (int j = 0; j < 12; j++) begin
        pa_q[j] <= pa_d[j];
      end
    end
  end

  // ---------------- stage 4: cube read / load write ----------------
  logic                 wr_en;
  logic signed [EW-1:0] corner [3][8];

  assign wr_en = v_q[3] && (kind3_q == KIND_LOAD) && en[4]
              && (LAW'(addr3_q) < LAW'(DEPTH));

  tlut_store #(.EW(EW), .AW(AW), .DEPTH(DEPTH)) u_store (
    .clk_i       (clk_i),
    .rd_en_i     (en[4]),
    .pair_addr_i (pa_q),
    .wr_en_i     (wr_en),
    .wr_addr_i   (AW'(addr3_q)),
    .wr_data_i   (val3_q),
    .corner_o    (corner)
  );

  // ---------------- stages 5..7: blend and clamp ----------------
  blend_en_t ben;

  assign ben.s4 = en[4];
  assign ben.s5 = en[5];
  assign ben.s6 = en[6];
  assign ben.s7 = en[7];

  tlut_blend #(.EW(EW), .FB(FB)) u_blend (
    .clk_i    (clk_i),
    .en_i     (ben),
    .corner_i (corner),
    .rf_i     (rf3_q),
    .gf_i     (gf3_q),
    .bf_i     (bf3_q),
    .fe_i     (fe3_q),
    .red_o    (red_out_o),
    .green_o  (green_out_o),
    .blue_o   (blue_out_o),
    .frame_o  (frame_last_o)
  );

endmodule

// ===== bench/trilinear_3d_color_lut_core_tb.sv =====
// ----------------------------------------------------------------------------
// trilinear_3d_color_lut_core_tb: self-checking bench for the 3D color LUT
// Streams cube loads and pixels with random gaps and output stalls, across
// several cube sizes. Expected colors come from a behavioral trilinear
// model that tracks the cube contents as the requests are accepted.
// ----------------------------------------------------------------------------
module trilinear_3d_color_lut_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlut_pkg::*;

  localparam int MAXN     = MAX_CUBE_SIZE_DEF;
  localparam int FRAC     = COLOR_FRAC_BITS_DEF;
  localparam int ONE      = 1 << FRAC;
  localparam int DEPTH    = 3 * MAXN * MAXN * MAXN;
  localparam int LIMIT    = 1000000;
  localparam int SETTLE   = 20;      // pipeline is 8 deep
  localparam int BATCH    = 80;      // minimum requests queued per cube size

  localparam logic [FRAC:0] C_ONE  = (FRAC+1)'(ONE);
  localparam logic [FRAC:0] C_ZERO = '0;
  localparam logic [FRAC:0] C_LSB  = (FRAC+1)'(1);

  typedef struct {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic signed [15:0] value;
    logic [FRAC:0]     red, green, blue;
    logic              fend;
  } lut_req_t;

  typedef struct {
    logic [FRAC:0] red, green, blue;
    logic          flast;
  } color_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic kind_i = KIND_LOAD;
  logic [ADDR_W-1:0] entry_address_i = '0;
  logic signed [15:0] entry_value_i = '0;
  logic [FRAC:0] red_in_i = '0, green_in_i = '0, blue_in_i = '0;
  logic frame_end_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [FRAC:0] red_out_o, green_out_o, blue_out_o;
  logic frame_last_o;

  trilinear_3d_color_lut_core dut (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o,
    .kind_i, .entry_address_i, .entry_value_i,
    .red_in_i, .green_in_i, .blue_in_i, .frame_end_i,
    .out_valid_o, .out_stall_i,
    .red_out_o, .green_out_o, .blue_out_o, .frame_last_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow cube, effective grid size and the write map used for stimulus
  logic signed [15:0] cube_mem [DEPTH];
  bit                 loaded [DEPTH];
  int                 grid_n = 33;

  lut_req_t  req_q [$];     // waiting to be driven
  color_t    color_q [$];   // predicted results in order
  lut_req_t  cur_req;
  bit        quiet;         // no idling on either side
  int        errors;
  int        cycles;
  int        n_queued;      // requests queued so far
  int        batch_start;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint blend(longint a, longint b, longint f);
    return (a * (ONE - f) + b * f + ONE / 2) >>> FRAC;
  endfunction

  function automatic void grid_pos(input logic [FRAC:0] v, output int idx,
                                   output longint frac);
    longint c, pos, i;
    c = (v > ONE) ? ONE : v;
    pos = c * (grid_n - 1);
    i = pos >>> FRAC;
    if (i > grid_n - 2) i = grid_n - 2;
    idx = int'(i);
    frac = pos - (i << FRAC);
  endfunction

  function automatic longint entry_at(int a);
    return (a < DEPTH) ? longint'(cube_mem[a]) : 0;
  endfunction

  // apply one accepted request to the shadow cube; pixels queue a result
  function automatic void map_request(lut_req_t rq);
    int ri, gi, bi, s2, a00, a10, a01, a11;
    longint rf, gf, bf, v, c00, c10, c01, c11, c0, c1;
    color_t res;
    logic [FRAC:0] ch_val [3];
    if (rq.kind == KIND_LOAD) begin
      if (rq.addr < DEPTH) cube_mem[rq.addr] = rq.value;
      return;
    end
    grid_pos(rq.red, ri, rf);
    grid_pos(rq.green, gi, gf);
    grid_pos(rq.blue, bi, bf);
    s2 = grid_n * grid_n;
    for (int ch = 0; ch < 3; ch++) begin
      a00 = ch * s2 * grid_n + bi * s2 + gi * grid_n + ri;
      a10 = a00 + grid_n;
      a01 = a00 + s2;
      a11 = a01 + grid_n;
      c00 = blend(entry_at(a00), entry_at(a00 + 1), rf);
      c10 = blend(entry_at(a10), entry_at(a10 + 1), rf);
      c01 = blend(entry_at(a01), entry_at(a01 + 1), rf);
      c11 = blend(entry_at(a11), entry_at(a11 + 1), rf);
      c0 = blend(c00, c10, gf);
      c1 = blend(c01, c11, gf);
      v = blend(c0, c1, bf);
      if (v < 0) v = 0;
      if (v > ONE) v = ONE;
      ch_val[ch] = v[FRAC:0];
    end
    res.red = ch_val[0];
    res.green = ch_val[1];
    res.blue = ch_val[2];
    res.flast = rq.fend;
    color_q.insert(color_q.size(), res);
  endfunction

  function automatic logic signed [15:0] corner_value();
    if ($urandom_range(9) < 7) return 16'($signed($urandom_range(5100)) - 512);
    return 16'($urandom);
  endfunction

  function automatic void add_load(int a, logic signed [15:0] v);
    lut_req_t rq;
    rq.kind = KIND_LOAD;
    rq.addr = a[ADDR_W-1:0];
    rq.value = v;
    rq.red = 13'($urandom);
    rq.green = 13'($urandom);
    rq.blue = 13'($urandom);
    rq.fend = 1'($urandom);
    if (a < DEPTH) loaded[a] = 1'b1;
    req_q.insert(req_q.size(), rq);
    n_queued++;
  endfunction

  // queue a pixel, loading first any of its 24 corners not yet written
  function automatic void add_pixel(logic [FRAC:0] r, logic [FRAC:0] g,
                                    logic [FRAC:0] b, logic fe);
    int ri, gi, bi, s2, base;
    longint f;
    lut_req_t rq;
    grid_pos(r, ri, f);
    grid_pos(g, gi, f);
    grid_pos(b, bi, f);
    s2 = grid_n * grid_n;
    for (int ch = 0; ch < 3; ch++)
      for (int db = 0; db < 2; db++)
        for (int dg = 0; dg < 2; dg++)
          for (int dr = 0; dr < 2; dr++) begin
            base = ch * s2 * grid_n + (bi + db) * s2 + (gi + dg) * grid_n + ri + dr;
            if (!loaded[base]) add_load(base, corner_value());
          end
    rq.kind = KIND_PIXEL;
    rq.addr = ADDR_W'($urandom);
    rq.value = 16'($urandom);
    rq.red = r;
    rq.green = g;
    rq.blue = b;
    rq.fend = fe;
    req_q.insert(req_q.size(), rq);
    n_queued++;
  endfunction

  function automatic logic [FRAC:0] near_color(logic [FRAC:0] c);
    int v;
    v = int'(c) + $signed($urandom_range(160)) - 80;
    if (v < 0) v = 0;
    if (v > 8191) v = 8191;
    return v[FRAC:0];
  endfunction

  function automatic logic [FRAC:0] any_color();
    case ($urandom_range(9))
      0: return 13'($urandom);              // includes saturating values
      1: return C_ONE;
      2: return C_ZERO;
      default: return 13'($urandom_range(ONE));
    endcase
  endfunction

  // request side: drive at the falling edge, take the handshake at rising
  bit took;
  bit held;    // request on the port still waits for its handshake
  int in_gap;

  always @(posedge clk_i) begin
    took = rst_ni && in_valid_i && !in_stall_o;
    if (took) map_request(cur_req);
  end

  always @(posedge clk_i) begin
    if (!rst_ni) held = 1'b0;
    else held = in_valid_i && in_stall_o;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (took) begin
        in_gap = quiet ? 0 : $urandom_range(19);
        took = 1'b0;
      end
      if (!(in_valid_i && held)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          in_valid_i <= 1'b1;
          kind_i <= cur_req.kind;
          entry_address_i <= cur_req.addr;
          entry_value_i <= cur_req.value;
          red_in_i <= cur_req.red;
          green_in_i <= cur_req.green;
          blue_in_i <= cur_req.blue;
          frame_end_i <= cur_req.fend;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result side: random stalls, compare at the rising edge
  int out_wait;

  always @(posedge clk_i) begin
    color_t exp_c;
    cycles++;
    if (cycles > LIMIT) begin
      $display("trilinear_3d_color_lut_core_tb NOT OK");
      $finish;
    end else if (rst_ni && out_valid_o && !out_stall_i) begin
      out_wait = quiet ? 0 : $urandom_range(19);
      if (color_q.size() == 0) begin
        report("result with no pixel pending");
      end else begin
        exp_c = color_q.pop_front();
        if (red_out_o !== exp_c.red)
          report($sformatf("red %0d, want %0d", red_out_o, exp_c.red));
        if (green_out_o !== exp_c.green)
          report($sformatf("green %0d, want %0d", green_out_o, exp_c.green));
        if (blue_out_o !== exp_c.blue)
          report($sformatf("blue %0d, want %0d", blue_out_o, exp_c.blue));
        if (frame_last_o !== exp_c.flast)
          report($sformatf("frame_last %0b, want %0b", frame_last_o, exp_c.flast));
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_wait > 0) begin
      out_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic drain();
    while (req_q.size() > 0 || in_valid_i || color_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_size(int v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CFG_W'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    grid_n = (v < 2) ? 2 : (v > MAXN) ? MAXN : v;
  endtask

  int sizes [10] = '{2, 3, 33, 17, 0, 63, 1, 5, 33, 2};
  logic [FRAC:0] pool [8][3];

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: store extremes, dropped loads, color extremes, saturation
    add_load(0, -16'sd32768);
    add_load(DEPTH - 1, 16'sd32767);
    add_load(DEPTH, 16'sd1234);
    add_load((1 << ADDR_W) - 1, -16'sd1);
    add_pixel(C_ZERO, C_ZERO, C_ZERO, 1'b0);
    add_pixel(C_ONE, C_ONE, C_ONE, 1'b1);
    add_pixel(13'h1fff, 13'h1fff, 13'h1fff, 1'b0);
    add_pixel(C_ONE + C_LSB, C_ZERO, C_ONE, 1'b1);
    add_pixel(C_ONE >> 1, 13'h0aaa, 13'h1555, 1'b0);
    add_pixel(C_LSB, C_ONE - C_LSB, 13'h0fff, 1'b1);
    drain();

    foreach (sizes[p]) begin
      set_size(sizes[p]);
      quiet = (p % 4 == 3);
      for (int k = 0; k < 8; k++)
        for (int c = 0; c < 3; c++) pool[k][c] = any_color();
      batch_start = n_queued;
      while (n_queued - batch_start < BATCH) begin
        int k;
        k = $urandom_range(7);
        if ($urandom_range(19) == 0)
          add_load($urandom_range((1 << ADDR_W) - 1), 16'($urandom));
        if (grid_n > 5 && $urandom_range(9) != 0)
          add_pixel(near_color(pool[k][0]), near_color(pool[k][1]),
                    near_color(pool[k][2]), 1'($urandom));
        else
          add_pixel(any_color(), any_color(), any_color(), 1'($urandom));
      end
      drain();
    end

    if (errors == 0) begin
      $display("trilinear_3d_color_lut_core_tb OK");
    end else begin
      $display("trilinear_3d_color_lut_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tlut_pkg.sv
src/tlut_ram.sv
src/tlut_store.sv
src/tlut_lerp.sv
src/tlut_blend.sv
src/trilinear_3d_color_lut_core.sv
bench/trilinear_3d_color_lut_core_tb.sv
